@@ sv/fpa_pkg.sv @@
// Shared types, codes and constants for the fixed partition allocator.
`default_nettype none

package fpa_pkg;

  localparam int PARTITIONS_DEF = 5;
  localparam int SIZE_BITS_DEF  = 16;
  localparam int NUM_SIZE_REGS  = 5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_PART0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_PART4 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUSY_MASK  = 3'd6;

  localparam logic [1:0] POLICY_FIRST  = 2'd0;
  localparam logic [1:0] POLICY_BEST   = 2'd1;
  localparam logic [1:0] POLICY_WORST  = 2'd2;
  localparam logic [1:0] POLICY_UNUSED = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_PLACED    = 2'd0;
  localparam logic [1:0] STATUS_WAIT      = 2'd1;
  localparam logic [1:0] STATUS_FREED     = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  localparam logic [31:0] SIZE_RESET [NUM_SIZE_REGS] = '{
    32'd100, 32'd500, 32'd200, 32'd300, 32'd600
  };

  typedef struct packed {
    logic        command;
    logic [7:0]  owner_tag;
    logic [15:0] request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  part_index;
    logic [15:0] part_size_before;
  } res_t;

endpackage

`default_nettype wire

@@ sv/fpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 5,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/fixed_partition_allocator.sv @@
// Fixed partition allocator: first, best or worst fit over a configured partition table.
`default_nettype none

// A request is taken when start is high and busy is low. Owners and remaining
// sizes live in two RAMs with registered read data; the request reads one
// partition per cycle and the cycle after the last read evaluates it and
// writes the chosen entry back; busy stays high from the transfer through that
// write. The result strobe shows in the cycle right after that write, together
// with busy going low, so a new start can be taken at the edge that ends the
// strobe cycle. The strobed result cannot be held off by the receiver. After
// reset a clearing pass loads the configured sizes into the RAM while busy
// stays high; a size write during that pass restarts it.
module fixed_partition_allocator #(
  parameter int PARTITIONS = fpa_pkg::PARTITIONS_DEF,
  parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire fpa_pkg::req_t                    item_i,
  output logic                                  result_valid_o,
  output fpa_pkg::res_t                         result_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fpa_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [fpa_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTITIONS - 1);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;
  logic                  ev_vld_q;
  logic [IDX_W-1:0]      ev_idx_q;
  logic [PARTITIONS-1:0] busy_q, busy_d;
  logic [1:0]            policy_q;
  logic [SIZE_BITS-1:0]  size_q [fpa_pkg::NUM_SIZE_REGS];
  logic                  res_vld_q;
  fpa_pkg::res_t         res_q;

  logic                  cmd_q;
  logic [7:0]            tag_q;
  logic [SIZE_BITS-1:0]  req_q;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      pick_q, pick_d;
  logic [SIZE_BITS-1:0]  best_q, best_d;
  logic [SIZE_BITS-1:0]  before_q, before_d;

  logic [7:0]            own_rdata;
  logic [SIZE_BITS-1:0]  rem_rdata;
  logic [SIZE_BITS-1:0]  left;
  logic                  take;

  localparam int CFG_INDEX_W_L = fpa_pkg::CFG_INDEX_W;
  logic                  accept;
  logic                  cfg_we;
  logic                  cfg_is_size;
  logic [CFG_INDEX_W_L-1:0] cfg_part;
  logic                  cfg_part_ok;

  logic [IDX_W-1:0]      size_sel;
  logic [SIZE_BITS-1:0]  size_rd;
  logic                  ram_we;
  logic                  own_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [7:0]            own_wdata;
  logic [SIZE_BITS-1:0]  rem_wdata;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_is_size = (cfg_index_i >= fpa_pkg::CFG_SIZE_PART0) &&
                       (cfg_index_i <= fpa_pkg::CFG_SIZE_PART4);
  assign cfg_part    = cfg_index_i - fpa_pkg::CFG_SIZE_PART0;
  assign cfg_part_ok = cfg_is_size && (32'(cfg_part) < 32'(PARTITIONS));

  // Scan evaluation: one entry per cycle, the data of each entry arrives in the cycle after its read.
  always_comb begin
    found_d  = found_q;
    pick_d   = pick_q;
    best_d   = best_q;
    before_d = before_q;
    take     = 1'b0;
    left     = rem_rdata - req_q;
    if (ev_vld_q) begin
      if (cmd_q == fpa_pkg::CMD_FREE) begin
        take = busy_q[ev_idx_q] && (own_rdata == tag_q) && !found_q;
      end else begin
        take = !busy_q[ev_idx_q] && (req_q <= rem_rdata) &&
               (policy_q != fpa_pkg::POLICY_UNUSED) &&
               (!found_q ||
                ((policy_q == fpa_pkg::POLICY_BEST) && (left < best_q)) ||
                ((policy_q == fpa_pkg::POLICY_WORST) && (left > best_q)));
      end
      if (take) begin
        found_d  = 1'b1;
        pick_d   = ev_idx_q;
        best_d   = left;
        before_d = rem_rdata;
      end
    end
  end

  assign size_sel = (state_q == ST_INIT) ? cnt_q : pick_d;
  assign size_rd  = size_q[size_sel];

  // RAM write port: clearing pass, request write-back, or size reload.
  // A size reload leaves the owner RAM alone.
  always_comb begin
    ram_we    = 1'b0;
    own_we    = 1'b0;
    ram_waddr = cnt_q;
    own_wdata = 8'd0;
    rem_wdata = size_rd;
    unique case (state_q)
      ST_INIT: begin
        ram_we = 1'b1;
        own_we = 1'b1;
      end
      ST_FLUSH: begin
        ram_we    = found_d;
        own_we    = found_d;
        ram_waddr = pick_d;
        if (cmd_q == fpa_pkg::CMD_ALLOC) begin
          own_wdata = tag_q;
          rem_wdata = before_d - req_q;
        end
      end
      ST_IDLE: begin
        ram_we    = cfg_we && cfg_part_ok;
        ram_waddr = cfg_part[IDX_W-1:0];
        rem_wdata = SIZE_BITS'(cfg_wdata_i);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    unique case (state_q)
      ST_INIT: begin
        if (cfg_we && cfg_is_size) begin
          cnt_d = '0;
        end else if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == LAST_IDX) begin
          state_d = ST_FLUSH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FLUSH: begin
        cnt_d   = '0;
        state_d = ST_IDLE;
        if (found_d) begin
          busy_d[pick_d] = (cmd_q == fpa_pkg::CMD_ALLOC);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we && (cfg_index_i == fpa_pkg::CFG_BUSY_MASK)) begin
      busy_d = cfg_wdata_i[PARTITIONS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cnt_q     <= '0;
      ev_vld_q  <= 1'b0;
      busy_q    <= '0;
      policy_q  <= fpa_pkg::POLICY_FIRST;
      res_vld_q <= 1'b0;
      found_q   <= 1'b0;
      for (int i = 0; i < fpa_pkg::NUM_SIZE_REGS; i++) begin
        size_q[i] <= SIZE_BITS'(fpa_pkg::SIZE_RESET[i]);
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ev_vld_q  <= (state_q == ST_SCAN);
      busy_q    <= busy_d;
      res_vld_q <= (state_q == ST_FLUSH);
      found_q   <= accept ? 1'b0 : found_d;
      if (cfg_we && (cfg_index_i == fpa_pkg::CFG_FIT_POLICY)) begin
        policy_q <= cfg_wdata_i[1:0];
      end
      if (cfg_we && cfg_is_size) begin
        size_q[cfg_part] <= SIZE_BITS'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q <= cnt_q;
    pick_q   <= pick_d;
    best_q   <= best_d;
    before_q <= before_d;
    if (accept) begin
      cmd_q <= item_i.command;
      tag_q <= item_i.owner_tag;
      req_q <= SIZE_BITS'(item_i.request_size);
    end
    if (state_q == ST_FLUSH) begin
      if (found_d) begin
        res_q.status           <= (cmd_q == fpa_pkg::CMD_ALLOC) ? fpa_pkg::STATUS_PLACED
                                                                 : fpa_pkg::STATUS_FREED;
        res_q.part_index       <= 3'(pick_d);
        res_q.part_size_before <= 16'(before_d);
      end else begin
        res_q.status           <= (cmd_q == fpa_pkg::CMD_ALLOC) ? fpa_pkg::STATUS_WAIT
                                                                 : fpa_pkg::STATUS_NOT_FOUND;
        res_q.part_index       <= 3'd0;
        res_q.part_size_before <= 16'd0;
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  fpa_ram #(
    .WIDTH (8),
    .DEPTH (PARTITIONS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (ram_waddr),
    .wdata_i (own_wdata),
    .raddr_i (cnt_q),
    .rdata_o (own_rdata)
  );

  fpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (PARTITIONS)
  ) u_remain_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (cnt_q),
    .rdata_o (rem_rdata)
  );

endmodule

`default_nettype wire
